// ----- hw/rtl/midi_note_pairing_tracker_assert.svh -----
// Assertion helpers for the note pairing tracker.
// Both sample on clk and are off while arst_n is low.
`ifndef MIDI_NOTE_PAIRING_TRACKER_ASSERT_SVH
`define MIDI_NOTE_PAIRING_TRACKER_ASSERT_SVH

// same-cycle implication
`define MNPT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MNPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/mnpt_pkg.sv -----
package mnpt_pkg;

	localparam int MAX_TRACKS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int CHANNELS = 16;
	localparam int NOTES = 128;

	localparam int TRACK_W = 2;
	localparam int CHAN_W = 4;
	localparam int NOTE_W = 7;
	localparam int VEL_W = 7;
	localparam int TICK_W = 32;
	localparam int CNT_W = 32;
	localparam int SLOT_IDX_W = TRACK_W + CHAN_W + NOTE_W;

	localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
	localparam logic [7:0] STATUS_CHAN_MASK = 8'h0F;
	localparam logic [7:0] TYPE_NOTE_ON = 8'h90;
	localparam logic [7:0] TYPE_NOTE_OFF = 8'h80;
	localparam logic [VEL_W-1:0] DEFAULT_VELOCITY = 7'd100;

	// action codes of an incoming word
	localparam logic [1:0] ACT_CHANNEL = 2'd0;
	localparam logic [1:0] ACT_TIMED = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	// operations queued for the back end
	localparam logic [1:0] OP_TIME = 2'd0;
	localparam logic [1:0] OP_ON = 2'd1;
	localparam logic [1:0] OP_OFF = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [TICK_W-1:0] tick;
		logic [7:0] status_byte;
		logic [TRACK_W-1:0] track;
		logic [NOTE_W-1:0] note_number;
		logic has_second;
		logic [VEL_W-1:0] second_byte;
	} evt_word_t;

	typedef struct packed {
		logic note_valid;
		logic [CHAN_W-1:0] out_channel;
		logic [NOTE_W-1:0] out_note;
		logic [VEL_W-1:0] out_velocity;
		logic [TICK_W-1:0] onset_tick;
		logic [TICK_W-1:0] stop_tick;
		logic [TICK_W-1:0] latest_tick;
		logic [CNT_W-1:0] notes_total;
		logic [CNT_W-1:0] overlap_total;
		logic [CNT_W-1:0] events_total;
	} res_word_t;

	typedef struct packed {
		logic [1:0] op;
		logic count_evt;
		logic raise_end;
		logic [TICK_W-1:0] tick;
		logic [CHAN_W-1:0] chan;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0] vel;
		logic [SLOT_IDX_W-1:0] slot_idx;
	} cmd_t;

	typedef struct packed {
		logic on;
		logic [TICK_W-1:0] start;
		logic [VEL_W-1:0] vel;
	} slot_t;

	localparam slot_t SLOT_RESET = '{on: 1'b0, start: '0, vel: DEFAULT_VELOCITY};

endpackage

// ----- hw/rtl/mnpt_ram.sv -----
module mnpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/mnpt_queue.sv -----
module mnpt_queue import mnpt_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mnpt_front.sv -----
module mnpt_front import mnpt_pkg::*; #(
	parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
	input logic evt_valid,
	output logic evt_ready,
	input evt_word_t evt,
	input logic q_full,
	input logic busy,
	output logic push,
	output cmd_t cmd
);

	logic [7:0] ev_type;
	logic track_ok;

	assign ev_type = evt.status_byte & STATUS_TYPE_MASK;
	// track field is narrow, so widen both sides before comparing
	assign track_ok = ({5'd0, evt.track} < 7'(MAX_TRACKS));

	assign evt_ready = !q_full && !busy;
	assign push = evt_valid && evt_ready;

	always_comb begin
		cmd = '0;
		cmd.tick = evt.tick;
		cmd.chan = CHAN_W'(evt.status_byte & STATUS_CHAN_MASK);
		cmd.note = evt.note_number;
		cmd.vel = evt.second_byte;
		cmd.slot_idx = {evt.track, cmd.chan, evt.note_number};
		cmd.op = OP_TIME;
		unique case (evt.action)
			ACT_CHANNEL: begin
				cmd.count_evt = 1'b1;
				cmd.raise_end = 1'b1;
				if (evt.has_second && track_ok) begin
					if (ev_type == TYPE_NOTE_ON && evt.second_byte != '0) begin
						cmd.op = OP_ON;
					end else if (ev_type == TYPE_NOTE_OFF || ev_type == TYPE_NOTE_ON) begin
						cmd.op = OP_OFF;
					end
				end
			end
			ACT_TIMED: begin
				cmd.raise_end = 1'b1;
			end
			ACT_FLUSH: begin
				if (track_ok) begin
					cmd.op = OP_FLUSH;
				end
			end
			default: begin
				cmd.op = OP_TIME;
			end
		endcase
	end

endmodule

// ----- hw/rtl/mnpt_back.sv -----
`include "midi_note_pairing_tracker_assert.svh"

module mnpt_back import mnpt_pkg::*; #(
	parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input cmd_t q_head,
	output logic pop,
	output logic busy,
	output logic res_valid,
	input logic res_ready,
	output res_word_t res
);

	localparam int TRACK_SLOTS = 1 << TRACK_W;
	localparam int TRACKS_USED = (MAX_TRACKS < TRACK_SLOTS) ? MAX_TRACKS : TRACK_SLOTS;
	localparam int DEPTH = TRACKS_USED * CHANNELS * NOTES;
	localparam int AW = $clog2(DEPTH);
	localparam int SLOT_W = $bits(slot_t);

	logic clearing_q;
	logic [AW-1:0] clr_addr_q;
	cmd_t cmd_s1;
	logic s1_valid_q;
	logic fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	slot_t fwd_data_q;
	logic [TICK_W-1:0] last_tick_q;
	logic [CNT_W-1:0] notes_q;
	logic [CNT_W-1:0] overlaps_q;
	logic [CNT_W-1:0] events_q;
	res_word_t res_q;
	logic res_valid_q;

	logic fire;
	logic advance;
	logic [AW-1:0] raddr;
	logic [AW-1:0] s1_addr;
	logic [SLOT_W-1:0] rdata;
	slot_t cur_slot;
	slot_t new_slot;
	logic slot_we;
	logic ram_we;
	logic [AW-1:0] waddr;
	slot_t wdata;
	logic emit;
	logic overlap_inc;
	logic [TICK_W-1:0] stop;
	logic [TICK_W-1:0] end_nx;
	logic [CNT_W-1:0] notes_nx;
	res_word_t res_nx;

	assign busy = clearing_q;
	assign fire = s1_valid_q && (!res_valid_q || res_ready);
	assign advance = !s1_valid_q || fire;
	assign pop = advance && q_valid && !clearing_q;
	assign s1_addr = cmd_s1.slot_idx[AW-1:0];
	// while held, keep reading the held slot so the registered data stays put
	assign raddr = advance ? q_head.slot_idx[AW-1:0] : s1_addr;

	// a write in the cycle of the read is not seen by it; take the last write instead
	assign cur_slot = (fwd_valid_q && fwd_addr_q == s1_addr) ? fwd_data_q : slot_t'(rdata);

	always_comb begin
		emit = 1'b0;
		overlap_inc = 1'b0;
		slot_we = 1'b0;
		stop = cmd_s1.tick;
		new_slot = cur_slot;
		new_slot.on = 1'b0;
		unique case (cmd_s1.op)
			OP_ON: begin
				slot_we = 1'b1;
				if (!cur_slot.on) begin
					new_slot = '{on: 1'b1, start: cmd_s1.tick, vel: cmd_s1.vel};
				end else begin
					new_slot = cur_slot;
					overlap_inc = 1'b1;
				end
			end
			OP_OFF: begin
				slot_we = 1'b1;
				emit = cur_slot.on && (cmd_s1.tick >= cur_slot.start);
			end
			OP_FLUSH: begin
				slot_we = 1'b1;
				stop = last_tick_q;
				emit = cur_slot.on && (last_tick_q >= cur_slot.start);
			end
			OP_TIME: begin
				slot_we = 1'b0;
			end
			default: begin
				slot_we = 1'b0;
			end
		endcase
	end

	assign end_nx = (cmd_s1.raise_end && cmd_s1.tick > last_tick_q) ? cmd_s1.tick : last_tick_q;
	assign notes_nx = notes_q + CNT_W'(emit);

	always_comb begin
		res_nx = '0;
		if (emit) begin
			res_nx.note_valid = 1'b1;
			res_nx.out_channel = cmd_s1.chan;
			res_nx.out_note = cmd_s1.note;
			res_nx.out_velocity = cur_slot.vel;
			res_nx.onset_tick = cur_slot.start;
			res_nx.stop_tick = stop;
		end
		res_nx.latest_tick = end_nx;
		res_nx.notes_total = notes_nx;
		res_nx.overlap_total = overlaps_q + CNT_W'(overlap_inc);
		res_nx.events_total = events_q + CNT_W'(cmd_s1.count_evt);
	end

	assign ram_we = clearing_q || (fire && slot_we);
	assign waddr = clearing_q ? clr_addr_q : s1_addr;
	assign wdata = clearing_q ? SLOT_RESET : new_slot;

	mnpt_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk(clk),
		.we(ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= q_head;
		end
		if (fire) begin
			res_q <= res_nx;
		end
		if (fire && slot_we) begin
			fwd_addr_q <= s1_addr;
			fwd_data_q <= new_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			s1_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
			last_tick_q <= '0;
			notes_q <= '0;
			overlaps_q <= '0;
			events_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			s1_valid_q <= pop || (s1_valid_q && !fire);
			if (fire && slot_we) begin
				fwd_valid_q <= 1'b1;
			end
			if (fire) begin
				last_tick_q <= end_nx;
				notes_q <= notes_nx;
				overlaps_q <= res_nx.overlap_total;
				events_q <= res_nx.events_total;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`MNPT_ASSERT_IMPL(a_no_pop_clearing, clearing_q, !pop, "word taken during clearing pass")
	`MNPT_ASSERT_IMPL(a_idle_clearing, clearing_q, !s1_valid_q && !res_valid_q, "work during clearing")
	`MNPT_ASSERT_NEXT(a_note_count, fire, notes_q == $past(notes_q) + CNT_W'(res_q.note_valid), "note count slip")
	`MNPT_ASSERT_NEXT(a_end_mono, 1'b1, last_tick_q >= $past(last_tick_q), "end tick fell")

endmodule

// ----- hw/rtl/midi_note_pairing_tracker.sv -----
// channel  | direction | handshake             | word
// evt      | in        | evt_valid / evt_ready | evt_word_t: one MIDI or flush event
// res      | out       | res_valid / res_ready | res_word_t: one result per event
//
// Throughput: one word a cycle once the clearing pass is over and while res drains;
//   a word passes the queue entry, the slot read, then the result register to res_valid.
// Slot state sits in one RAM with a registered read; a write that collides with the
//   next word's read is forwarded, so back-to-back words on one slot are exact.
// Reset (arst_n low) clears control state, then a clearing pass writes every slot
//   to off, velocity 100, tick 0: min(MAX_TRACKS, 4) * 2048 slots, 8192 by default.
//   evt_ready stays low during the pass.
// A stalled res side fills the result register, then the queue, then drops evt_ready.

module midi_note_pairing_tracker import mnpt_pkg::*; #(
	parameter int MAX_TRACKS = MAX_TRACKS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic evt_valid,
	output logic evt_ready,
	input evt_word_t evt,
	output logic res_valid,
	input logic res_ready,
	output res_word_t res
);

	// front end: classify each word into a slot operation
	cmd_t cmd;
	logic push;
	logic q_full;
	logic q_not_empty;
	logic pop;
	cmd_t q_head;
	logic busy;

	mnpt_front #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_front (
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.q_full(q_full),
		.busy(busy),
		.push(push),
		.cmd(cmd)
	);

	// short queue decouples the classifier from the slot read-modify-write
	mnpt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(cmd),
		.full(q_full),
		.pop(pop),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	// back end: slot table, end tick, counters and the result register
	mnpt_back #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_not_empty),
		.q_head(q_head),
		.pop(pop),
		.busy(busy),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

endmodule
